[design/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Table geometry, command and status codes, and the structs that pass
// between the controller and the cells of the chain.
// ----------------------------------------------------------------------------
package skt_pkg;

  // table geometry
  localparam int DEPTH       = 32;
  localparam int VALUE_BITS  = 16;
  localparam int KEY_W       = 8;
  localparam int OUT_VALUE_W = 16;
  localparam int POS_W       = 5;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LIST   = 2'd2
  } skt_cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_MISSING  = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_FULL     = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_EMPTY    = 3'd6
  } skt_status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  ins;   // commit an insert this cycle
    logic [KEY_W-1:0]      key;   // search key
    logic [VALUE_BITS-1:0] value; // value for a new entry
  } skt_ctl_t;

  // handed from each cell to its right-hand neighbour
  typedef struct packed {
    logic                  lt_occ; // occupied and key below search key
    logic                  ge_occ; // occupied and key not below search key
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } skt_link_t;

endpackage

[design/skt_cell.sv]
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key table
// Holds a key and value, compares against the broadcast search key and on
// insert either holds, takes its left neighbour's entry or loads the new one.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic              clk,
  input  skt_pkg::skt_ctl_t ctl,
  input  logic              occ,
  input  skt_pkg::skt_link_t left,
  output skt_pkg::skt_link_t right,
  output logic              match,
  output logic              boundary
);
  import skt_pkg::*;

  logic [KEY_W-1:0]      key;
  logic [VALUE_BITS-1:0] value;
  logic                  lt;

  // compare against the search key
  assign lt       = occ && ($signed(key) < $signed(ctl.key));
  assign match    = occ && (key == ctl.key);
  // first cell not below the key whose left neighbour is below it
  assign boundary = !lt && left.lt_occ;

  assign right = '{lt_occ: lt, ge_occ: occ && !lt, key: key, value: value};

  // entries at or above the insert point move one place right
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left.ge_occ) begin
        key   <= left.key;
        value <= left.value;
      end else if (boundary) begin
        key   <= ctl.key;
        value <= ctl.value;
      end
    end
  end

endmodule

[design/sorted_key_table.sv]
// Lookup and insert: command registered into S_EXEC, result then registered and strobed on done.
// List: one entry a cycle from the cell read-out while in S_LIST, or one ST_EMPTY when empty.
// Lookup and insert make one compare-and-shift pass; busy holds off new commands until idle.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset clears the entry count; cell contents are undefined until written.
// ----------------------------------------------------------------------------
// sorted_key_table: sorted key/value table on a chain of cells
// Lookup, insert-if-absent and in-order listing of signed 8-bit keys with
// value handles, kept in ascending order by shifting along the chain.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic signed [7:0]            search_key,
  input  logic [15:0]                  entry_value,
  output logic                         done,
  output logic [2:0]                   status,
  output logic signed [7:0]            found_key,
  output logic [15:0]                  found_value,
  output logic [4:0]                   position,
  output logic                         last
);
  import skt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t                state;
  skt_cmd_t              cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      list_idx;

  skt_ctl_t              ctl;
  skt_link_t             link [DEPTH+1];
  logic [DEPTH-1:0]      occ;
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      boundary;
  logic [DEPTH-1:0]      sel;

  logic                  accept;
  logic                  found;
  logic                  full;
  logic                  list_last;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      below_idx;
  logic [KEY_W-1:0]      rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // left end of the chain: everything sits above an imaginary smallest entry
  assign link[0] = '{lt_occ: 1'b1, ge_occ: 1'b0, key: '0, value: '0};

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g] = (CNT_W'(g) < count);
    assign sel[g] = (state == S_LIST) ? (list_idx == IDX_W'(g)) : match[g];

    skt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ[g]),
      .left     (link[g]),
      .right    (link[g+1]),
      .match    (match[g]),
      .boundary (boundary[g])
    );
  end

  // encode hit and insert positions, read out the selected entry
  always_comb begin
    hit_idx   = '0;
    below_idx = '0;
    rd_key    = '0;
    rd_value  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i])    hit_idx   = hit_idx | IDX_W'(i);
      if (boundary[i]) below_idx = below_idx | IDX_W'(i);
      if (sel[i]) begin
        rd_key   = rd_key | link[i+1].key;
        rd_value = rd_value | link[i+1].value;
      end
    end
  end

  assign found     = |match;
  assign full      = (count == CNT_W'(DEPTH));
  assign list_last = ((CNT_W'(list_idx) + CNT_W'(1)) == count);

  // insert commits in the execute cycle when the key is new and there is room
  assign ctl = '{ins:   (state == S_EXEC) && (cmd_r == CMD_INSERT) && !found && !full,
                 key:   key_r,
                 value: value_r};

  // control, entry count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      list_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= skt_cmd_t'(cmd);
            key_r    <= search_key;
            value_r  <= VALUE_BITS'(entry_value);
            list_idx <= '0;
            case (cmd)
              CMD_LOOKUP, CMD_INSERT: state <= S_EXEC;
              CMD_LIST:               state <= S_LIST;
              default:                state <= S_IDLE;
            endcase
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          last  <= 1'b1;
          state <= S_IDLE;
          if (found) begin
            status      <= (cmd_r == CMD_INSERT) ? ST_PRESENT : ST_FOUND;
            found_key   <= rd_key;
            found_value <= OUT_VALUE_W'(rd_value);
            position    <= POS_W'(hit_idx);
          end else if (cmd_r != CMD_INSERT) begin
            status      <= ST_MISSING;
            found_key   <= key_r;
            found_value <= '0;
            position    <= '0;
          end else if (full) begin
            status      <= ST_FULL;
            found_key   <= key_r;
            found_value <= '0;
            position    <= '0;
          end else begin
            status      <= ST_INSERTED;
            found_key   <= key_r;
            found_value <= OUT_VALUE_W'(value_r);
            position    <= POS_W'(below_idx);
            count       <= count + CNT_W'(1);
          end
        end
        S_LIST: begin
          done <= 1'b1;
          if (count == '0) begin
            status      <= ST_EMPTY;
            found_key   <= '0;
            found_value <= '0;
            position    <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            status      <= ST_ENTRY;
            found_key   <= rd_key;
            found_value <= OUT_VALUE_W'(rd_value);
            position    <= POS_W'(list_idx);
            last        <= list_last;
            list_idx    <= list_idx + IDX_W'(1);
            if (list_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result strobe without a command in progress");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED) |-> count == $past(count) + CNT_W'(1))
    else $error("insert reported without the count growing");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> $onehot0(match))
    else $error("key held by more than one cell");

  a_single_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> $onehot0(boundary))
    else $error("more than one insert point in the chain");

endmodule
